FILE: hdl/rcbp_pkg.sv
`timescale 1ns / 1ps

package rcbp_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int STATE_FRAC_BITS = 12;
  localparam int STATE_W         = 32;

  localparam int HPC_W      = 16;
  localparam int LPC_W      = 17;
  localparam int COEF_FRAC  = 16;
  localparam int CFG_DATA_W = LPC_W;
  localparam int CFG_IDX_W  = 2;

  // x difference in state format, and the multiplier's first operand
  localparam int XD_W   = SAMPLE_WIDTH + 1 + STATE_FRAC_BITS;
  localparam int SUM_W  = ((XD_W > STATE_W) ? XD_W : STATE_W) + 1;
  localparam int MB_W   = LPC_W + 1;
  localparam int PROD_W = SUM_W + MB_W;
  localparam int RND_W  = PROD_W - COEF_FRAC;

  // sample in state format and the output path
  localparam int XF_W = SAMPLE_WIDTH + STATE_FRAC_BITS;
  localparam int Y_W  = ((XF_W > STATE_W) ? XF_W : STATE_W) + 1;
  localparam int YR_W = Y_W + 1 - STATE_FRAC_BITS;

  localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic [LPC_W-1:0] LP_UNITY = LPC_W'(1) << COEF_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HP_COEF  = 2'd0,
    CFG_LP_COEF  = 2'd1,
    CFG_OUT_MODE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_BANDPASS = 1'b0,
    MODE_BANDSTOP = 1'b1
  } out_mode_e;

  typedef struct packed {
    logic in_ready;
    logic sel_lp;
    logic do_hp;
    logic do_lp;
  } seq_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic fin_free;
  } seq_sts_t;

endpackage

FILE: hdl/rcbp_mac.sv
`timescale 1ns / 1ps

// Shared multiply unit: round_half_up(a * b / 2^16)
module rcbp_mac import rcbp_pkg::*; (
  input  logic signed [SUM_W-1:0] a_i,
  input  logic signed [MB_W-1:0]  b_i,
  output logic signed [RND_W-1:0] r_o
);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (COEF_FRAC - 1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;

  assign prod     = a_i * b_i;
  assign prod_rnd = prod + RND_HALF;
  assign r_o      = prod_rnd[PROD_W-1:COEF_FRAC];

endmodule

FILE: hdl/rcbp_seq.sv
`timescale 1ns / 1ps

module rcbp_seq import rcbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  seq_sts_t sts_i,
  output seq_ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HP   = 3'b010,
    S_LP   = 3'b100
  } seq_state_e;

  seq_state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    ctl_o        = '0;
    ctl_o.sel_lp = (state_q == S_LP);
    case (state_q)
      S_IDLE: begin
        ctl_o.in_ready = 1'b1;
        if (sts_i.in_valid) state_d = S_HP;
      end
      S_HP: begin
        ctl_o.do_hp = 1'b1;
        state_d     = S_LP;
      end
      S_LP: begin
        // wait here while the output stage is still full
        if (sts_i.fin_free) begin
          ctl_o.do_lp    = 1'b1;
          ctl_o.in_ready = 1'b1;
          state_d        = sts_i.in_valid ? S_HP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/rcbp_fmt.sv
`timescale 1ns / 1ps

// Output stage: one finished lp value waits here, then (subtracted from the sample
// in band-stop mode) gets rounded, saturated and moved into the output register.
module rcbp_fmt import rcbp_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic signed [STATE_W-1:0]      lp_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  input  logic                           clip_i,
  input  out_mode_e                      mode_i,
  output logic                           fin_free_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_o,
  output logic                           clipped_o
);

  localparam logic signed [Y_W:0] Y_HALF = (Y_W + 1)'(1) << (STATE_FRAC_BITS - 1);

  logic                           fin_valid_q;
  logic signed [STATE_W-1:0]      fin_lp_q;
  logic signed [SAMPLE_WIDTH-1:0] fin_x_q;
  logic                           fin_clip_q;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_q;
  logic                           out_clip_q;

  logic                           out_free;
  logic                           fin_move;
  logic signed [Y_W-1:0]          xf;
  logic signed [Y_W-1:0]          y;
  logic signed [Y_W:0]            y_rnd;
  logic signed [YR_W-1:0]         y_sh;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           y_clip;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_move   = fin_valid_q && out_free;
  assign fin_free_o = !fin_valid_q || out_free;

  always_comb begin
    xf    = Y_W'(fin_x_q) <<< STATE_FRAC_BITS;
    y     = (mode_i == MODE_BANDSTOP) ? (xf - Y_W'(fin_lp_q)) : Y_W'(fin_lp_q);
    y_rnd = (Y_W + 1)'(y) + Y_HALF;
    y_sh  = y_rnd[Y_W:STATE_FRAC_BITS];
    if (y_sh > SAMPLE_MAX) begin
      y_sat  = SAMPLE_MAX;
      y_clip = 1'b1;
    end else if (y_sh < SAMPLE_MIN) begin
      y_sat  = SAMPLE_MIN;
      y_clip = 1'b1;
    end else begin
      y_sat  = y_sh[SAMPLE_WIDTH-1:0];
      y_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        fin_valid_q <= 1'b1;
      end else if (fin_move) begin
        fin_valid_q <= 1'b0;
      end
      if (fin_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fin_lp_q   <= lp_i;
      fin_x_q    <= x_i;
      fin_clip_q <= clip_i;
    end
    if (fin_move) begin
      out_data_q <= y_sat;
      out_clip_q <= fin_clip_q || y_clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_data_q;
  assign clipped_o   = out_clip_q;

endmodule

FILE: hdl/rc_bandpass_bandstop_filter.sv
`timescale 1ns / 1ps

// Channel | Handshake                  | Payload
// --------+----------------------------+----------------------------------
// in      | in_valid_i / in_ready_o    | sample_i (16b signed)
// out     | out_valid_o / out_ready_i  | filtered_o (16b signed), clipped_o
// cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i (2b), cfg_data_i (17b)
//
// One shared multiplier does the high-pass product in the HP state, then the
// low-pass product in the LP state (held while the output stage is full).
// A result goes through the formatting register and the output register to
// out_valid_o; a new sample is taken in the same cycle as the low-pass step.
// Output stall: one result waits in the output register and one more in the
// formatting stage, after that the low-pass step holds and input is refused.
// Reset clears all filter state; hp coefficient 0, lp coefficient unity,
// band-pass mode. cfg_ready_o is always high.
module rc_bandpass_bandstop_filter import rcbp_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_o,
  output logic                           clipped_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i
);

  seq_ctl_t ctl;
  seq_sts_t sts;
  logic     fin_free;
  logic     in_fire;

  logic [HPC_W-1:0] hp_coef_q;
  logic [LPC_W-1:0] lp_coef_q;
  out_mode_e        mode_q;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] prev_q;
  logic signed [STATE_W-1:0]      hp_q;
  logic signed [STATE_W-1:0]      lp_q;
  logic                           clip_hp_q;

  logic signed [SAMPLE_WIDTH:0]   xdiff;
  logic signed [SUM_W-1:0]        hp_sum;
  logic signed [SUM_W-1:0]        lp_diff;
  logic signed [SUM_W-1:0]        mac_a;
  logic signed [MB_W-1:0]         mac_b;
  logic signed [RND_W-1:0]        mac_r;
  logic signed [RND_W-1:0]        hp_wide;
  logic signed [STATE_W-1:0]      hp_d;
  logic                           hp_clip;
  logic signed [RND_W:0]          lp_wide;
  logic signed [STATE_W-1:0]      lp_d;
  logic                           lp_clip;

  assign in_fire      = in_valid_i && ctl.in_ready;
  assign sts.in_valid = in_valid_i;
  assign sts.fin_free = fin_free;
  assign in_ready_o   = ctl.in_ready;
  assign cfg_ready_o  = 1'b1;

  rcbp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // shared multiplier operands: hp step, then lp step
  assign xdiff   = (SAMPLE_WIDTH + 1)'(x_q) - (SAMPLE_WIDTH + 1)'(prev_q);
  assign hp_sum  = SUM_W'(hp_q) + (SUM_W'(xdiff) <<< STATE_FRAC_BITS);
  assign lp_diff = SUM_W'(hp_q) - SUM_W'(lp_q);
  assign mac_a   = ctl.sel_lp ? lp_diff : hp_sum;
  assign mac_b   = ctl.sel_lp ? MB_W'(lp_coef_q) : MB_W'(hp_coef_q);

  rcbp_mac u_mac (
    .a_i (mac_a),
    .b_i (mac_b),
    .r_o (mac_r)
  );

  always_comb begin
    if (hp_coef_q == '0) begin
      hp_wide = RND_W'(x_q) <<< STATE_FRAC_BITS;
    end else begin
      hp_wide = mac_r;
    end
    if (hp_wide > STATE_MAX) begin
      hp_d    = STATE_MAX;
      hp_clip = 1'b1;
    end else if (hp_wide < STATE_MIN) begin
      hp_d    = STATE_MIN;
      hp_clip = 1'b1;
    end else begin
      hp_d    = hp_wide[STATE_W-1:0];
      hp_clip = 1'b0;
    end
  end

  always_comb begin
    // coefficient of unity or more passes hp straight through
    if (lp_coef_q >= LP_UNITY) begin
      lp_wide = (RND_W + 1)'(hp_q);
    end else begin
      lp_wide = (RND_W + 1)'(lp_q) + (RND_W + 1)'(mac_r);
    end
    if (lp_wide > STATE_MAX) begin
      lp_d    = STATE_MAX;
      lp_clip = 1'b1;
    end else if (lp_wide < STATE_MIN) begin
      lp_d    = STATE_MIN;
      lp_clip = 1'b1;
    end else begin
      lp_d    = lp_wide[STATE_W-1:0];
      lp_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_coef_q <= '0;
      lp_coef_q <= LP_UNITY;
      mode_q    <= MODE_BANDPASS;
      prev_q    <= '0;
      hp_q      <= '0;
      lp_q      <= '0;
      clip_hp_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_HP_COEF:  hp_coef_q <= cfg_data_i[HPC_W-1:0];
          CFG_LP_COEF:  lp_coef_q <= cfg_data_i[LPC_W-1:0];
          CFG_OUT_MODE: mode_q    <= out_mode_e'(cfg_data_i[0]);
          default: ;
        endcase
      end
      if (ctl.do_hp) begin
        prev_q    <= x_q;
        hp_q      <= hp_d;
        clip_hp_q <= hp_clip;
      end
      if (ctl.do_lp) begin
        lp_q <= lp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= sample_i;
    end
  end

  rcbp_fmt u_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.do_lp),
    .lp_i        (lp_d),
    .x_i         (x_q),
    .clip_i      (clip_hp_q || lp_clip),
    .mode_i      (mode_q),
    .fin_free_o  (fin_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_o  (filtered_o),
    .clipped_o   (clipped_o)
  );

endmodule

FILE: hdl/rcbp_checker.sv
`timescale 1ns / 1ps

module rcbp_checker import rcbp_pkg::*; (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] filtered_i,
  input logic                           clipped_i,
  input logic                           cfg_ready_i
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a held result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(filtered_i) && $stable(clipped_i))
    else $error("result changed while stalled");

  // the high-pass step follows every accepted sample, so no back-to-back accept
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample accepted during high-pass step");

  // no stall on the register port
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("register port not ready");

endmodule

bind rc_bandpass_bandstop_filter rcbp_checker u_rcbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .filtered_i  (filtered_o),
  .clipped_i   (clipped_o),
  .cfg_ready_i (cfg_ready_o)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import rcbp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;  // unmapped register index
  localparam int WD_LIMIT    = 2000;
  localparam int CFG_PAUSE   = 4;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 96;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [CFG_IDX_W-1:0]           idx;
    logic [CFG_DATA_W-1:0]          data;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic                           known;
    logic signed [SAMPLE_WIDTH-1:0] k_filt;
    logic                           k_clip;
  } stim_row_t;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] filt;
    logic                           clip;
  } result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic signed [SAMPLE_WIDTH-1:0] filtered_o;
  logic                           clipped_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [CFG_IDX_W-1:0]           cfg_index_i;
  logic [CFG_DATA_W-1:0]          cfg_data_i;

  rc_bandpass_bandstop_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_o  (filtered_o),
    .clipped_o   (clipped_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // filter model state and register copies
  logic [HPC_W-1:0] hp_coef;
  logic [LPC_W-1:0] lp_coef;
  out_mode_e        mode;
  longint           last_sample;
  longint           hp_state;
  longint           lp_state;

  result_t pending_results[$];
  int      mismatches;
  int      walk_pos;
  bit      tx_idle;
  int      rx_hold;
  int      rx_run;
  int      idle_cycles;
  result_t head;

  // 33 rows: extremes after reset, band-stop, saturation, masking, bypass cases
  stim_row_t directed_rows [33] = '{
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MAX,     1'b1, SAMPLE_MAX,   1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MIN,     1'b1, SAMPLE_MIN,   1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       16'sd0,         1'b1, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       -16'sd1,        1'b1, -16'sd1,      1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       16'sd1,         1'b1, 16'sd1,       1'b0},
    '{ROW_WRITE,  CFG_OUT_MODE, 17'd1,       16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MAX,     1'b1, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MIN,     1'b1, 16'sd0,       1'b0},
    '{ROW_WRITE,  CFG_HP_COEF,  17'd1,       16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_WRITE,  CFG_OUT_MODE, 17'd0,       16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MAX,     1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MAX,     1'b0, 16'sd0,       1'b0},
    '{ROW_WRITE,  CFG_HP_COEF,  17'd65535,   16'sd0,         1'b0, 16'sd0,       1'b0},
    // full-scale step against a decayed high-pass: output saturates low
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MIN,     1'b1, SAMPLE_MIN,   1'b1},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MAX,     1'b0, 16'sd0,       1'b0},
    '{ROW_WRITE,  CFG_HP_COEF,  17'd0,       16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MIN,     1'b1, SAMPLE_MIN,   1'b0},
    '{ROW_WRITE,  CFG_LP_COEF,  17'd0,       16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_WRITE,  CFG_OUT_MODE, 17'd1,       16'sd0,         1'b0, 16'sd0,       1'b0},
    // low-pass frozen at full negative scale: band-stop overflows high
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       SAMPLE_MAX,     1'b1, SAMPLE_MAX,   1'b1},
    '{ROW_WRITE,  CFG_LP_COEF,  17'h1FFFF,   16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       16'sd100,       1'b1, 16'sd0,       1'b0},
    '{ROW_WRITE,  CFG_NONE,     17'h1FFFF,   16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       -16'sd5,        1'b1, 16'sd0,       1'b0},
    // bit 16 is dropped from the hp coefficient, leaving the bypass value
    '{ROW_WRITE,  CFG_HP_COEF,  17'h10000,   16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       16'sd7,         1'b1, 16'sd0,       1'b0},
    '{ROW_WRITE,  CFG_OUT_MODE, 17'd2,       16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       16'sd1234,      1'b1, 16'sd1234,    1'b0},
    '{ROW_WRITE,  CFG_LP_COEF,  17'd32768,   16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_WRITE,  CFG_HP_COEF,  17'd40000,   16'sd0,         1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       16'sd20000,     1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       -16'sd20000,    1'b0, 16'sd0,       1'b0},
    '{ROW_SAMPLE, CFG_NONE,     17'd0,       16'sd0,         1'b0, 16'sd0,       1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint round_up_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi, inout bit clip);
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  task automatic filter_step(input logic signed [SAMPLE_WIDTH-1:0] x, output result_t res);
    longint xs;
    longint xf;
    longint hp;
    longint lp;
    longint y;
    bit     clip;
    clip = 1'b0;
    xs   = longint'(x);
    xf   = xs * (longint'(1) <<< STATE_FRAC_BITS);
    if (hp_coef == '0) begin
      hp = xf;
    end else begin
      hp = round_up_shift((hp_state + (xs - last_sample) * (longint'(1) <<< STATE_FRAC_BITS))
                          * longint'(hp_coef), COEF_FRAC);
    end
    hp = saturate(hp, longint'(STATE_MIN), longint'(STATE_MAX), clip);
    last_sample = xs;
    hp_state    = hp;
    if (lp_coef >= LP_UNITY) begin
      lp = hp;
    end else begin
      lp = lp_state + round_up_shift((hp - lp_state) * longint'(lp_coef), COEF_FRAC);
    end
    lp = saturate(lp, longint'(STATE_MIN), longint'(STATE_MAX), clip);
    lp_state = lp;
    y = (mode == MODE_BANDSTOP) ? (xf - lp) : lp;
    y = saturate(round_up_shift(y, STATE_FRAC_BITS), longint'(SAMPLE_MIN),
                 longint'(SAMPLE_MAX), clip);
    res.filt = SAMPLE_WIDTH'(y);
    res.clip = clip;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int gap_len();
    int r;
    if (!tx_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] next_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return SAMPLE_WIDTH'($urandom);
    if (k < 6) begin
      case ($urandom_range(0, 3))
        0:       return SAMPLE_MAX;
        1:       return SAMPLE_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    // slow random walk, so the filters see in-band signal too
    walk_pos = walk_pos + int'($urandom_range(0, 2000)) - 1000;
    if (walk_pos > 32767) walk_pos = 32767;
    if (walk_pos < -32768) walk_pos = -32768;
    return SAMPLE_WIDTH'(walk_pos);
  endfunction

  // register writes only once the pipeline has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CFG_PAUSE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_HP_COEF:  hp_coef = data[HPC_W-1:0];
      CFG_LP_COEF:  lp_coef = data;
      CFG_OUT_MODE: mode    = out_mode_e'(data[0]);
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] x, input logic known,
                             input logic signed [SAMPLE_WIDTH-1:0] k_filt, input logic k_clip);
    int      gap;
    result_t res;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= x;
    do @(posedge clk_i); while (!in_ready_o);
    filter_step(x, res);
    if (known) begin
      res.filt = k_filt;
      res.clip = k_clip;
    end
    pending_results.push_back(res);
  endtask

  // result checker and output back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result without pending transaction", longint'(filtered_o), 0);
      end else begin
        head = pending_results.pop_front();
        if (filtered_o !== head.filt)
          report_mismatch("filtered", longint'(filtered_o), longint'(head.filt));
        if (clipped_o !== head.clip)
          report_mismatch("clipped", longint'(clipped_o), longint'(head.clip));
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (rx_run > 0) begin
      rx_run--;
      out_ready_i <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:1]: begin
          rx_run = $urandom_range(100, 300);
          out_ready_i <= 1'b1;
        end
        [2:27]: begin
          rx_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(19, 59) : $urandom_range(0, 2);
          out_ready_i <= 1'b0;
        end
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WD_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, WD_LIMIT);
      $display("[rc_bandpass_bandstop_filter] ERROR");
      $finish;
    end
  end

  initial begin
    int                    p;
    int                    n;
    logic [CFG_DATA_W-1:0] hp_val;
    logic [CFG_DATA_W-1:0] lp_val;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_HP_COEF;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    hp_coef     = '0;
    lp_coef     = LP_UNITY;
    mode        = MODE_BANDPASS;
    last_sample = 0;
    hp_state    = 0;
    lp_state    = 0;
    mismatches  = 0;
    walk_pos    = 0;
    tx_idle     = 1'b1;
    rx_hold     = 0;
    rx_run      = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_sample(directed_rows[i].smp, directed_rows[i].known,
                    directed_rows[i].k_filt, directed_rows[i].k_clip);
    end

    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       hp_val = '0;
        1:       hp_val = 17'd65535;
        2:       hp_val = CFG_DATA_W'($urandom);
        default: hp_val = CFG_DATA_W'($urandom_range(1, 255));
      endcase
      case (p % 5)
        0:       lp_val = '0;
        1:       lp_val = LP_UNITY;
        2:       lp_val = CFG_DATA_W'($urandom_range(65537, 131071));
        3:       lp_val = CFG_DATA_W'($urandom_range(1, 65535));
        default: lp_val = CFG_DATA_W'($urandom_range(1, 2048));
      endcase
      if ($urandom_range(0, 1) == 1) write_reg(CFG_NONE, CFG_DATA_W'($urandom));
      write_reg(CFG_HP_COEF, hp_val);
      write_reg(CFG_LP_COEF, lp_val);
      // upper data bits are junk, only bit 0 selects the mode
      write_reg(CFG_OUT_MODE, {16'($urandom), 1'((p / 2) % 2)});
      tx_idle = ($urandom_range(0, 3) != 0);
      for (n = 0; n < PHASE_ITEMS; n++)
        send_sample(next_sample(), 1'b0, '0, 1'b0);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("[rc_bandpass_bandstop_filter] OK");
    else
      $display("[rc_bandpass_bandstop_filter] ERROR");
    $finish;
  end

endmodule

FILE: rc_bandpass_bandstop_filter.f
hdl/rcbp_pkg.sv
hdl/rcbp_mac.sv
hdl/rcbp_seq.sv
hdl/rcbp_fmt.sv
hdl/rc_bandpass_bandstop_filter.sv
hdl/rcbp_checker.sv
verif/tb.sv
